// File: hdl/assert_macros.svh
// Assertion macros used by the allocator executor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge out of reset.
`define NFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the cycle after.
`define NFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/nfa_pkg.sv
// Shared types and constants of the next-fit slot allocator.
package nfa_pkg;

  localparam int unsigned REQ_W     = 32;
  localparam int unsigned ADDR_W    = 26;
  localparam int unsigned BYTES_W   = 27;
  localparam int unsigned CAP_W     = 16;
  localparam int unsigned NEED_W    = 21;
  localparam int unsigned MAX_MOVES = 32;
  localparam int unsigned REMAP_WORDS_PER_MOVE = 3;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_COMPACT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NO_RECORD = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_e;

  typedef struct packed {
    op_e                 op;
    logic                reject;
    logic [NEED_W-1:0]   need;
    logic [ADDR_W-1:0]   addr;
    logic [CAP_W-1:0]    cap;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   old_address;
    logic [BYTES_W-1:0]  block_bytes;
    logic                moved;
    logic                remap_recorded;
    logic                last;
  } res_t;

  function automatic res_t plain_res(input status_e st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

// File: hdl/next_fit_bitmap_slot_allocator.sv
// Top level of the next-fit slot allocator with compaction.
//
//  channel  dir  tdata                                   tuser        tlast
//  s_axis   in   request/free address/remap capacity      operation    -
//  m_axis   out  address/old address/bytes/moved/remap    status       last of item
//
// Front end takes one transfer, then rounds up by reciprocal multiply, low then high half.
// Allocate: one sweep of the record table per probe of the next-fit scan.
// Free and compact: a pass over the record table, plus output stalls.
// Slot occupancy is held as record extents; no clearing pass after reset.
module next_fit_bitmap_slot_allocator import nfa_pkg::*; #(
  parameter int unsigned NUM_SLOTS    = 65536,
  parameter int unsigned SLOT_BYTES   = 1024,
  parameter int unsigned RECORD_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // request_bytes, free_address, remap_capacity
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // address, old_address, block_bytes, moved, remap_recorded
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  nfa_front #(
    .NUM_SLOTS  (NUM_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .op_i         (s_axis_tuser),
    .req_i        (s_axis_tdata[31:0]),
    .addr_i       (s_axis_tdata[57:32]),
    .cap_i        (s_axis_tdata[73:58]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_o       (push_cmd)
  );

  nfa_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_o        (pop_cmd)
  );

  nfa_back #(
    .NUM_SLOTS    (NUM_SLOTS),
    .SLOT_BYTES   (SLOT_BYTES),
    .RECORD_COUNT (RECORD_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {7'b0, res.remap_recorded, res.moved, res.block_bytes,
                         res.old_address, res.address};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

// File: hdl/nfa_front.sv
// Request front end: takes transfers, checks sizes and rounds bytes up to slots.
module nfa_front import nfa_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 65536,
  parameter int unsigned SLOT_BYTES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [1:0]        op_i,
  input  logic [REQ_W-1:0]  req_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [CAP_W-1:0]  cap_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output cmd_t              push_o
);

  typedef enum logic [1:0] {FR_IDLE, FR_MLO, FR_MHI, FR_PUSH} fr_state_e;

  localparam int unsigned NW  = REQ_W + 1;
  localparam int unsigned LW  = $clog2(SLOT_BYTES);
  localparam int unsigned SH  = NW + LW;
  localparam int unsigned MGW = NW + 1;
  localparam int unsigned PRW = MGW + NW;
  localparam int unsigned LOW = 17;
  localparam longint unsigned MAX_BYTES = longint'(NUM_SLOTS) * longint'(SLOT_BYTES);
  // ceil(2^SH / SLOT_BYTES): exact floor division for any NW-bit dividend
  localparam longint unsigned MAGIC =
    ((64'd1 << SH) + 64'(SLOT_BYTES) - 64'd1) / 64'(SLOT_BYTES);
  localparam logic [MGW-1:0] MAGIC_V = MGW'(MAGIC);

  fr_state_e             state_q, state_d;
  cmd_t                  cmd_q, cmd_d;
  logic [NW-1:0]         rem_q, rem_d;
  logic [PRW-1:0]        acc_q, acc_d;
  logic [MGW+LOW-1:0]    prod_lo;
  logic [MGW+NW-LOW-1:0] prod_hi;
  logic                  reject;

  assign reject = (op_i == OP_ALLOC) && ((req_i == '0) || (64'(req_i) > MAX_BYTES));
  assign prod_lo = (MGW + LOW)'(MAGIC_V) * (MGW + LOW)'(rem_q[LOW-1:0]);
  assign prod_hi = (MGW + NW - LOW)'(MAGIC_V) * (MGW + NW - LOW)'(rem_q[NW-1:LOW]);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    unique case (state_q)
      FR_IDLE: begin
        if (s_valid_i) begin
          cmd_d.op     = op_e'(op_i);
          cmd_d.reject = reject;
          cmd_d.need   = '0;
          cmd_d.addr   = addr_i;
          cmd_d.cap    = cap_i;
          acc_d        = '0;
          if (op_i == OP_ALLOC && !reject) begin
            rem_d   = NW'(req_i) + NW'(SLOT_BYTES - 1);
            state_d = FR_MLO;
          end else begin
            state_d = FR_PUSH;
          end
        end
      end
      FR_MLO: begin
        acc_d   = PRW'(prod_lo);
        state_d = FR_MHI;
      end
      FR_MHI: begin
        acc_d   = acc_q + (PRW'(prod_hi) << LOW);
        state_d = FR_PUSH;
      end
      FR_PUSH: begin
        if (push_ready_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign s_ready_o    = (state_q == FR_IDLE);
  assign push_valid_o = (state_q == FR_PUSH);

  always_comb begin
    push_o      = cmd_q;
    push_o.need = NEED_W'(acc_q >> SH);
  end

endmodule

// File: hdl/nfa_cmd_fifo.sv
// Two-entry command queue between front end and executor.
module nfa_cmd_fifo import nfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_o        = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= push_i;
    end
  end

endmodule

// File: hdl/nfa_back.sv
// Executor: record table, next-fit scan, free lookup, compaction and result register.
`include "assert_macros.svh"
module nfa_back import nfa_pkg::*; #(
  parameter int unsigned NUM_SLOTS    = 65536,
  parameter int unsigned SLOT_BYTES   = 1024,
  parameter int unsigned RECORD_COUNT = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  typedef enum logic [3:0] {
    BK_IDLE, BK_A_CHECK, BK_A_SWEEP, BK_A_DECIDE,
    BK_F_SCAN, BK_F_EMIT, BK_C_SCAN, BK_C_END, BK_EMIT
  } bk_state_e;

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned XW = CW + 2;
  localparam int unsigned IW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
  localparam int unsigned KW = $clog2(RECORD_COUNT + 1);
  localparam int unsigned PW = (CW + 17 > BYTES_W) ? CW + 17 : BYTES_W;
  localparam int unsigned WW = $clog2(REMAP_WORDS_PER_MOVE * RECORD_COUNT + 4);
  localparam int unsigned MW = $clog2(MAX_MOVES + 1);

  function automatic logic [PW-1:0] mul_sb(input logic [CW-1:0] x);
    return PW'(x) * PW'(SLOT_BYTES);
  endfunction

  bk_state_e state_q, state_d;

  logic [RECORD_COUNT-1:0] rv_q;
  logic [SW-1:0]           rs_q [RECORD_COUNT];
  logic [CW-1:0]           rl_q [RECORD_COUNT];

  logic          wr_en, wr_v;
  logic [IW-1:0] wr_idx;
  logic [SW-1:0] wr_s;
  logic [CW-1:0] wr_l;

  logic [KW-1:0]    idx_q, idx_d;
  logic [SW-1:0]    p_q, p_d;
  logic [XW-1:0]    s_q, s_d;
  logic [CW-1:0]    need_q, need_d;
  logic             inside_q, inside_d;
  logic [CW-1:0]    end_q, end_d;
  logic [CW-1:0]    minu_q, minu_d;
  logic [CW-1:0]    cursor_q, cursor_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [CW-1:0]    dest_q, dest_d;
  logic [WW-1:0]    words_q, words_d;
  logic [MW-1:0]    n_q, n_d;
  logic             pend_valid_q, pend_valid_d;
  res_t             pend_q, pend_d;
  res_t             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  logic          emit, can_emit;
  res_t          emit_res;
  logic [IW-1:0] ridx;
  logic          cur_v;
  logic [CW-1:0] cur_s, cur_l, cur_end, run;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          last_idx, move, rep, stall;
  logic [CW:0]   p_nxt;
  res_t          mv_res;

  assign ridx     = idx_q[IW-1:0];
  assign cur_v    = rv_q[ridx];
  assign cur_s    = CW'(rs_q[ridx]);
  assign cur_l    = rl_q[ridx];
  assign cur_end  = cur_s + cur_l;
  assign can_emit = !out_valid_q || res_ready_i;
  assign last_idx = (idx_q == KW'(RECORD_COUNT - 1));
  assign run      = minu_q - CW'(p_q);
  assign p_nxt    = (CW + 1)'(minu_q) + 1'b1;
  assign move     = cur_v && (cur_s != dest_q);
  assign rep      = move && (n_q < MW'(MAX_MOVES));
  assign stall    = rep && pend_valid_q && !can_emit;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = RECORD_COUNT - 1; i >= 0; i--) begin
      if (!rv_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    mv_res             = '0;
    mv_res.status      = ST_OK;
    mv_res.address     = ADDR_W'(mul_sb(dest_q));
    mv_res.old_address = ADDR_W'(mul_sb(cur_s));
    mv_res.block_bytes = BYTES_W'(mul_sb(cur_l));
    mv_res.moved       = 1'b1;
    mv_res.remap_recorded =
      ((CAP_W + 1)'(words_q) + (CAP_W + 1)'(REMAP_WORDS_PER_MOVE)) <= (CAP_W + 1)'(cap_q);
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    p_d          = p_q;
    s_d          = s_q;
    need_d       = need_q;
    inside_d     = inside_q;
    end_d        = end_q;
    minu_d       = minu_q;
    cursor_d     = cursor_q;
    addr_d       = addr_q;
    cap_d        = cap_q;
    dest_d       = dest_q;
    words_d      = words_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    res_d        = res_q;
    emit         = 1'b0;
    emit_res     = res_q;
    wr_en        = 1'b0;
    wr_v         = 1'b0;
    wr_idx       = ridx;
    wr_s         = '0;
    wr_l         = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_ALLOC: begin
              if (cmd_i.reject) begin
                res_d   = plain_res(ST_NO_SPACE);
                state_d = BK_EMIT;
              end else begin
                need_d  = CW'(cmd_i.need);
                p_d     = (cursor_q == CW'(NUM_SLOTS)) ? '0 : SW'(cursor_q);
                s_d     = '0;
                state_d = BK_A_CHECK;
              end
            end
            OP_FREE: begin
              addr_d  = cmd_i.addr;
              idx_d   = '0;
              state_d = BK_F_SCAN;
            end
            OP_COMPACT: begin
              cap_d        = cmd_i.cap;
              idx_d        = '0;
              dest_d       = '0;
              words_d      = '0;
              n_d          = '0;
              pend_valid_d = 1'b0;
              state_d      = BK_C_SCAN;
            end
            default: begin
              res_d   = plain_res(ST_NO_SPACE);
              state_d = BK_EMIT;
            end
          endcase
        end
      end
      BK_A_CHECK: begin
        if (s_q + XW'(need_q) > XW'(NUM_SLOTS)) begin
          res_d   = plain_res(ST_NO_SPACE);
          state_d = BK_EMIT;
        end else begin
          idx_d    = '0;
          inside_d = 1'b0;
          minu_d   = CW'(NUM_SLOTS);
          state_d  = BK_A_SWEEP;
        end
      end
      BK_A_SWEEP: begin
        if (cur_v) begin
          if (CW'(p_q) >= cur_s && CW'(p_q) < cur_end) begin
            inside_d = 1'b1;
            end_d    = cur_end;
          end else if (cur_s > CW'(p_q) && cur_s < minu_q) begin
            minu_d = cur_s;
          end
        end
        idx_d = idx_q + 1'b1;
        if (last_idx) state_d = BK_A_DECIDE;
      end
      BK_A_DECIDE: begin
        if (inside_q) begin
          // blocked probe: jump past the whole used extent
          s_d     = s_q + XW'(end_q) - XW'(p_q);
          p_d     = (end_q == CW'(NUM_SLOTS)) ? '0 : SW'(end_q);
          state_d = BK_A_CHECK;
        end else if (run >= need_q) begin
          if (!free_found) begin
            res_d = plain_res(ST_NO_RECORD);
          end else begin
            wr_en             = 1'b1;
            wr_v              = 1'b1;
            wr_idx            = free_idx;
            wr_s              = p_q;
            wr_l              = need_q;
            cursor_d          = CW'(p_q) + need_q;
            res_d             = plain_res(ST_OK);
            res_d.address     = ADDR_W'(mul_sb(CW'(p_q)));
            res_d.block_bytes = BYTES_W'(mul_sb(need_q));
          end
          state_d = BK_EMIT;
        end else begin
          // short run: skip past the slot that ended it
          s_d     = s_q + XW'(run) + 1'b1;
          p_d     = (p_nxt >= (CW + 1)'(NUM_SLOTS)) ?
                    SW'(p_nxt - (CW + 1)'(NUM_SLOTS)) : SW'(p_nxt);
          state_d = BK_A_CHECK;
        end
      end
      BK_F_SCAN: begin
        if (cur_v && mul_sb(cur_s) == PW'(addr_q)) begin
          state_d = BK_F_EMIT;
        end else if (last_idx) begin
          res_d   = plain_res(ST_BAD_ADDR);
          state_d = BK_EMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      BK_F_EMIT: begin
        if (can_emit) begin
          emit                 = 1'b1;
          emit_res             = plain_res(ST_OK);
          emit_res.address     = addr_q;
          emit_res.block_bytes = BYTES_W'(mul_sb(cur_l));
          wr_en                = 1'b1;
          if (cur_s < cursor_q) cursor_d = cur_s;
          state_d = BK_IDLE;
        end
      end
      BK_C_SCAN: begin
        if (!stall) begin
          if (cur_v) dest_d = dest_q + cur_l;
          if (move) begin
            wr_en = 1'b1;
            wr_v  = 1'b1;
            wr_s  = SW'(dest_q);
            wr_l  = cur_l;
            if (mv_res.remap_recorded) words_d = words_q + WW'(REMAP_WORDS_PER_MOVE);
          end
          if (rep) begin
            if (pend_valid_q) begin
              emit     = 1'b1;
              emit_res = pend_q;
            end
            pend_d       = mv_res;
            pend_valid_d = 1'b1;
            n_d          = n_q + 1'b1;
          end
          idx_d = idx_q + 1'b1;
          if (last_idx) state_d = BK_C_END;
        end
      end
      BK_C_END: begin
        if (can_emit) begin
          emit = 1'b1;
          if (pend_valid_q) begin
            emit_res      = pend_q;
            emit_res.last = 1'b1;
          end else begin
            emit_res = plain_res(ST_OK);
          end
          pend_valid_d = 1'b0;
          cursor_d     = dest_q;
          state_d      = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_res;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      rv_q         <= '0;
      cursor_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      n_q          <= '0;
    end else begin
      state_q      <= state_d;
      cursor_q     <= cursor_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      n_q          <= n_d;
      if (wr_en) rv_q[wr_idx] <= wr_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rs_q[wr_idx] <= wr_s;
      rl_q[wr_idx] <= wr_l;
    end
    idx_q    <= idx_d;
    p_q      <= p_d;
    s_q      <= s_d;
    need_q   <= need_d;
    inside_q <= inside_d;
    end_q    <= end_d;
    minu_q   <= minu_d;
    addr_q   <= addr_d;
    cap_q    <= cap_d;
    dest_q   <= dest_d;
    words_q  <= words_d;
    pend_q   <= pend_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign cmd_ready_o = (state_q == BK_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `NFA_ASSERT(a_cursor_range, cursor_q <= CW'(NUM_SLOTS), "cursor beyond pool")
  `NFA_ASSERT(a_pend_compact, !pend_valid_q || state_q == BK_C_SCAN || state_q == BK_C_END, "stray pending move")
  `NFA_ASSERT(a_moves_cap, n_q <= MW'(MAX_MOVES), "move report count overrun")
  `NFA_ASSERT_NEXT(a_cmd_leaves_idle, cmd_valid_i && cmd_ready_o, state_q != BK_IDLE, "command dropped")

endmodule

// File: tb/tb_next_fit_bitmap_slot_allocator.sv
// Self-checking testbench for the next-fit bitmap slot allocator with compaction.
`timescale 1ns / 1ps

module tb_next_fit_bitmap_slot_allocator;
  import nfa_pkg::*;

  localparam int unsigned POOL_SLOTS = 65536;
  localparam int unsigned SLOT_SIZE  = 1024;
  localparam int unsigned RECORDS    = 32;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // request_bytes, free_address, remap_capacity
  logic [1:0]  s_axis_tuser = '0;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;       // address, old_address, block_bytes, moved, remap_recorded
  logic [1:0]  m_axis_tuser;       // status
  logic        m_axis_tlast;

  next_fit_bitmap_slot_allocator uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #1 clk_i = ~clk_i;

  // predicted allocator state
  bit          slot_used_map [POOL_SLOTS];
  bit          rec_valid [RECORDS];
  int unsigned rec_start [RECORDS];
  int unsigned rec_slots [RECORDS];
  int unsigned cursor;

  res_t pending_results [$];
  int unsigned error_count = 0;

  function automatic res_t status_only(status_e st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void mark_run(int unsigned start, int unsigned count, bit used);
    for (int unsigned s = start; s < start + count && s < POOL_SLOTS; s++)
      slot_used_map[s] = used;
  endfunction

  function automatic void predict_alloc(logic [31:0] req);
    longint unsigned need64;
    int unsigned need, scanned, probe, run, r;
    res_t res;
    need64 = (longint'(req) + SLOT_SIZE - 1) / SLOT_SIZE;
    if (need64 == 0 || need64 > POOL_SLOTS) begin
      pending_results.push_back(status_only(ST_NO_SPACE));
      return;
    end
    need = 32'(need64);
    scanned = 0;
    while (scanned + need <= POOL_SLOTS) begin
      probe = (cursor + scanned) % POOL_SLOTS;
      run = 0;
      while (probe + run < POOL_SLOTS && run < need && !slot_used_map[probe + run])
        run++;
      if (run == need) begin
        for (r = 0; r < RECORDS; r++)
          if (!rec_valid[r]) break;
        if (r == RECORDS) begin
          pending_results.push_back(status_only(ST_NO_RECORD));
          return;
        end
        rec_valid[r] = 1'b1;
        rec_start[r] = probe;
        rec_slots[r] = need;
        mark_run(probe, need, 1'b1);
        cursor = probe + need;
        res = status_only(ST_OK);
        res.address = probe * SLOT_SIZE;
        res.block_bytes = longint'(need) * SLOT_SIZE;
        pending_results.push_back(res);
        return;
      end
      scanned += (run > 0) ? run + 1 : 1;
    end
    pending_results.push_back(status_only(ST_NO_SPACE));
  endfunction

  function automatic void predict_free(logic [25:0] addr);
    res_t res;
    for (int r = 0; r < RECORDS; r++) begin
      if (rec_valid[r] && longint'(rec_start[r]) * SLOT_SIZE == addr) begin
        mark_run(rec_start[r], rec_slots[r], 1'b0);
        if (rec_start[r] < cursor) cursor = rec_start[r];
        res = status_only(ST_OK);
        res.address = addr;
        res.block_bytes = longint'(rec_slots[r]) * SLOT_SIZE;
        pending_results.push_back(res);
        rec_valid[r] = 1'b0;
        rec_start[r] = 0;
        rec_slots[r] = 0;
        return;
      end
    end
    pending_results.push_back(status_only(ST_BAD_ADDR));
  endfunction

  function automatic void predict_compact(logic [15:0] cap);
    int unsigned dest, words, n;
    res_t moves [MAX_MOVES];
    dest = 0;
    words = 0;
    n = 0;
    for (int s = 0; s < POOL_SLOTS; s++) slot_used_map[s] = 1'b0;
    for (int r = 0; r < RECORDS; r++) begin
      if (!rec_valid[r]) continue;
      if (rec_start[r] != dest) begin
        if (n < MAX_MOVES) begin
          moves[n] = '0;
          moves[n].status = ST_OK;
          moves[n].address = dest * SLOT_SIZE;
          moves[n].old_address = rec_start[r] * SLOT_SIZE;
          moves[n].block_bytes = longint'(rec_slots[r]) * SLOT_SIZE;
          moves[n].moved = 1'b1;
          if (words + REMAP_WORDS_PER_MOVE <= cap) begin
            words += REMAP_WORDS_PER_MOVE;
            moves[n].remap_recorded = 1'b1;
          end
          n++;
        end
        rec_start[r] = dest;
      end
      mark_run(dest, rec_slots[r], 1'b1);
      dest += rec_slots[r];
    end
    cursor = dest;
    if (n == 0) begin
      pending_results.push_back(status_only(ST_OK));
      return;
    end
    moves[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(moves[i]);
  endfunction

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one transfer on the input side; tvalid stays high when no gap follows
  task automatic send_item(logic [1:0] op, logic [31:0] req, logic [25:0] addr,
                           logic [15:0] cap);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, cap, addr, req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (op)
      OP_ALLOC:   predict_alloc(req);
      OP_FREE:    predict_free(addr);
      OP_COMPACT: predict_compact(cap);
      default:    pending_results.push_back(status_only(ST_NO_SPACE));
    endcase
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic alloc_req(logic [31:0] req);
    send_item(OP_ALLOC, req, $urandom, $urandom);
  endtask

  task automatic free_req(logic [25:0] addr);
    send_item(OP_FREE, $urandom, addr, $urandom);
  endtask

  task automatic compact_req(logic [15:0] cap);
    send_item(OP_COMPACT, $urandom, $urandom, cap);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [25:0] live_address();
    int unsigned k;
    k = $urandom_range(0, RECORDS - 1);
    for (int i = 0; i < RECORDS; i++)
      if (rec_valid[(k + i) % RECORDS]) return rec_start[(k + i) % RECORDS] * SLOT_SIZE;
    return $urandom;
  endfunction

  task automatic test_size_edges();
    alloc_req(32'd0);
    alloc_req(32'h0400_0000);       // whole pool
    alloc_req(32'd1);               // no space left
    free_req(26'd0);
    alloc_req(32'h0400_0001);       // one slot too many
    alloc_req(32'hFFFF_FFFF);       // would wrap when rounding
    alloc_req(32'd1);
    alloc_req(32'd1025);
    alloc_req(32'd1024);
    send_item(2'd3, $urandom, $urandom, $urandom);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 31; i++) alloc_req($urandom_range(1, 3 * SLOT_SIZE));
  endtask

  task automatic test_free_and_compact();
    free_req(26'h3FF_FFFF);
    free_req(live_address());
    free_req(live_address());
    free_req(live_address());
    compact_req(16'd0);
    compact_req(16'hFFFF);          // already packed
    free_req(live_address());
    free_req(live_address());
    compact_req(16'd4);             // room for one move's remap words only
    wait_drained();
  endtask

  task automatic test_random(int unsigned count);
    int unsigned p;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      p = $urandom_range(0, 99);
      if (p < 48) alloc_req($urandom_range(1, 8 * SLOT_SIZE));
      else if (p < 53) alloc_req($urandom_range(1, 32'h0400_0000));
      else if (p < 58) alloc_req($urandom);
      else if (p < 83) free_req(live_address());
      else if (p < 89) free_req($urandom);
      else if (p < 98) compact_req($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom);
      else send_item(2'd3, $urandom, $urandom, $urandom);
    end
  endtask

  // receiver back-pressure
  initial begin
    int unsigned stall;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        stall = idle_len();
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.status = status_e'(m_axis_tuser);
      got.address = m_axis_tdata[25:0];
      got.old_address = m_axis_tdata[51:26];
      got.block_bytes = m_axis_tdata[78:52];
      got.moved = m_axis_tdata[79];
      got.remap_recorded = m_axis_tdata[80];
      got.last = m_axis_tlast;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer %p", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[87:81] !== '0) begin
          $display("%0t: expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int r = 0; r < RECORDS; r++) begin
      rec_valid[r] = 1'b0;
      rec_start[r] = 0;
      rec_slots[r] = 0;
    end
    cursor = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_size_edges();
    test_table_full();
    test_free_and_compact();
    test_random(240);
    wait_drained();
    repeat (3000) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0)
      $display("tb_next_fit_bitmap_slot_allocator: clean");
    else
      $display("tb_next_fit_bitmap_slot_allocator: errors");
    $finish;
  end

  initial begin
    #8000000;
    $display("tb_next_fit_bitmap_slot_allocator: errors");
    $finish;
  end

endmodule
